>>> src/bounded_deque_core_defines.svh
// assertion macros used by the deque core rtl
`ifndef BOUNDED_DEQUE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_CORE_DEFINES_SVH

// checked only while out of reset
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/bdq_pkg.sv
package bdq_pkg;

  // storage geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ITEM_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_POP_BACK   = 2'd1,
    FUNC_PUSH_FRONT = 2'd2,
    FUNC_POP_FRONT  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one request as seen by every cell, at most one bit set
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } cell_ctrl_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic                 valid;
    logic [ITEM_BITS-1:0] data;
  } cell_link_t;

endpackage

>>> src/bdq_req_if.sv
interface bdq_req_if
  import bdq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);
endinterface

>>> src/bdq_rsp_if.sv
interface bdq_rsp_if
  import bdq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic [COUNT_W-1:0]  count_after;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output data_out, output count_after, output status,
                  input ready);
  modport sink   (input valid, input data_out, input count_after, input status,
                  output ready);
endinterface

>>> src/bounded_deque_core.sv
// Double-ended queue of up to DEPTH items held in a row of cells.
// Request channel req_i carries func (add back, take back, add front,
// take front) and data_in; response channel rsp_o returns one item per
// request with data_out (the item taken, else zero), count_after and status
// (ok, empty on take, full on add). A refused request changes nothing.
// The front item always sits in cell 0: front adds and takes shift every
// cell by one place at once, back adds and takes act on the cell
// at the occupied boundary.
// The response appears in the output register in the cycle after the
// request is accepted. Throughput: one request per cycle while the receiver
// does not stall, as the whole cell row updates at once on each request.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// response; no clearing pass is needed.
// When the receiver stalls the response holds in its register and req_i
// ready falls, so no further request is taken until the response leaves.
module bounded_deque_core
  import bdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

`include "bounded_deque_core_defines.svh"

  cell_link_t           link  [DEPTH+2];
  logic [ITEM_BITS-1:0] tails [DEPTH];
  logic [ITEM_BITS-1:0] tail_item;
  logic [ITEM_BITS-1:0] item;
  logic [DEPTH-1:0]     valid_vec;
  cell_ctrl_t           ctrl;
  func_e                func;
  logic                 accept, empty, full;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                rsp_valid_q;
  logic [DATA_W-1:0]   data_q, data_d;
  status_e             status_q, status_d;

  assign func   = func_e'(req_i.func);
  assign item   = ITEM_BITS'(req_i.data_in);
  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  // row ends: cell 0 sees the new item on its left, the last cell an empty slot
  assign link[0].valid       = 1'b1;
  assign link[0].data        = item;
  assign link[DEPTH+1].valid = 1'b0;
  assign link[DEPTH+1].data  = '0;

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .item_i  (item),
      .left_i  (link[i]),
      .right_i (link[i+2]),
      .cell_o  (link[i+1]),
      .tail_o  (tails[i])
    );
    assign valid_vec[i] = link[i+1].valid;
  end

  assign empty = !link[1].valid;
  assign full  = link[DEPTH].valid;

  // only one cell drives a non-zero tail item
  always_comb begin
    tail_item = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_item = tail_item | tails[i];
    end
  end

  // decode the request against the current fill
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    data_d   = '0;
    status_d = ST_OK;
    unique case (func)
      FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push_back = accept;
          count_d        = count_q + 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.pop_back = accept;
          count_d       = count_q - 1'b1;
          data_d        = DATA_W'(tail_item);
        end
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push_front = accept;
          count_d         = count_q + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept;
          count_d        = count_q - 1'b1;
          data_d         = DATA_W'(link[1].data);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // fill count and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  logic [CNT_W-1:0] rsp_count_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q      <= data_d;
      status_q    <= status_d;
      rsp_count_q <= count_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.data_out    = data_q;
  assign rsp_o.count_after = COUNT_W'(rsp_count_q);
  assign rsp_o.status      = status_q;

  // checks
  `BDQ_ASSERT_ALWAYS(a_count_matches_cells, count_q == CNT_W'($countones(valid_vec)), "fill count differs from occupied cells")
  `BDQ_ASSERT(a_cells_packed, (valid_vec & (valid_vec + 1'b1)) == '0, "occupied cells not packed from the front")
  `BDQ_ASSERT(a_empty_take_refused, accept && empty && (func == FUNC_POP_BACK || func == FUNC_POP_FRONT) |=> rsp_o.valid && rsp_o.status == ST_EMPTY && $stable(valid_vec), "take from empty queue not refused")
  `BDQ_ASSERT(a_stall_holds_queue, rsp_valid_q && !rsp_o.ready |=> $stable(count_q), "queue changed while response stalled")

endmodule

>>> src/bdq_cell.sv
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [ITEM_BITS-1:0] item_i,
  input  cell_link_t           left_i,
  input  cell_link_t           right_i,
  output cell_link_t           cell_o,
  output logic [ITEM_BITS-1:0] tail_o
);

  logic                 valid_q, valid_d;
  logic [ITEM_BITS-1:0] data_q, data_d;

  // front ops shift the whole row, back ops touch only the boundary cell
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.push_front) begin
      valid_d = left_i.valid;
      data_d  = left_i.data;
    end else if (ctrl_i.pop_front) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end else if (ctrl_i.push_back && !valid_q && left_i.valid) begin
      valid_d = 1'b1;
      data_d  = item_i;
    end else if (ctrl_i.pop_back && valid_q && !right_i.valid) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // last occupied cell offers its item for a take from the back
  assign tail_o = (valid_q && !right_i.valid) ? data_q : '0;

  assign cell_o.valid = valid_q;
  assign cell_o.data  = data_q;

endmodule

>>> sim/tb_bounded_deque_core.sv
`timescale 1ns / 1ps

module tb_bounded_deque_core;
  import bdq_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1820;
  localparam int unsigned CALM_TAIL_ITEMS = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned PRESSURE_ITEMS  = 20;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS     = 60;

  // one predicted response
  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    status_e            status;
  } deque_result_t;

  // shadow deque with the queue of responses still owed by the block
  class deque_shadow;
    logic [ITEM_BITS-1:0] slots [DEPTH];
    int unsigned          head;
    int unsigned          fill;
    int unsigned          deepest;
    deque_result_t        awaited [$];
    int unsigned          mismatches;
    int unsigned          noted;
    int unsigned          checked;
    int unsigned          empty_refusals;
    int unsigned          full_refusals;

    function void reset_state();
      head = 0;
      fill = 0;
      deepest = 0;
      awaited.delete();
    endfunction

    // work out the response owed for an accepted request
    function void note_request(func_e op, logic [DATA_W-1:0] din);
      deque_result_t r;
      r.data   = '0;
      r.status = ST_OK;
      noted++;
      case (op)
        FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
            full_refusals++;
          end else if (op == FUNC_PUSH_BACK) begin
            slots[(head + fill) % DEPTH] = din[ITEM_BITS-1:0];
            fill++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = din[ITEM_BITS-1:0];
            fill++;
          end
        end
        FUNC_POP_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
          end else begin
            r.data = DATA_W'(slots[(head + fill - 1) % DEPTH]);
            fill--;
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
          end else begin
            r.data = DATA_W'(slots[head]);
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
      endcase
      if (fill > deepest) deepest = fill;
      r.count = COUNT_W'(fill);
      awaited.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // compare a response against the oldest one owed
    task check_response(logic [DATA_W-1:0] dout, logic [COUNT_W-1:0] cnt,
                        logic [STATUS_W-1:0] st);
      deque_result_t want;
      if (awaited.size() == 0) begin
        report("response arrived with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (dout !== want.data)
        report($sformatf("data_out %h, predicted %h", dout, want.data));
      if (cnt !== want.count)
        report($sformatf("count_after %0d, predicted %0d", cnt, want.count));
      if (st !== want.status)
        report($sformatf("status %0d, predicted %s", st, want.status.name()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  deque_shadow shadow;
  bit          req_gaps_on;
  bit          rsp_gaps_on;
  bit          hold_off_go;
  int unsigned cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watch both channels: note accepted requests, check accepted responses
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        shadow.note_request(func_e'(req_if.func), req_if.data_in);
      if (rsp_if.valid && rsp_if.ready)
        shadow.check_response(rsp_if.data_out, rsp_if.count_after, rsp_if.status);
    end
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // give up on a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles,
             shadow.awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one request and wait until the block takes it
  task automatic send_request(func_e op, logic [DATA_W-1:0] din);
    req_if.valid   <= 1'b1;
    req_if.func    <= op;
    req_if.data_in <= din;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (req_gaps_on && $urandom_range(0, 2) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // item values leaning towards the extremes now and then
  function automatic logic [DATA_W-1:0] pick_item();
    logic [DATA_W-1:0] one_hot;
    one_hot = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // add or take with the given chance of an add, end picked at random
  function automatic func_e pick_op(int unsigned add_pct);
    bit at_front;
    at_front = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < add_pct)
      return at_front ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    return at_front ? FUNC_POP_FRONT : FUNC_POP_BACK;
  endfunction

  // main sequence
  initial begin
    int unsigned       sent;
    int unsigned       seg_len;
    int unsigned       add_pct;
    logic [DATA_W-1:0] fill_item;

    shadow = new;
    shadow.reset_state();
    req_gaps_on    = 1'b1;
    rsp_gaps_on    = 1'b1;
    hold_off_go    = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_PUSH_BACK;
    req_if.data_in = '0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: takes on empty, both ends, wrap at the front, fill to full, adds on full
    send_request(FUNC_POP_BACK, $urandom);
    send_request(FUNC_POP_FRONT, $urandom);
    send_request(FUNC_PUSH_FRONT, '1);
    send_request(FUNC_POP_BACK, '0);
    send_request(FUNC_PUSH_BACK, '0);
    send_request(FUNC_POP_FRONT, '1);
    for (int i = 0; i < DEPTH; i++) begin
      fill_item = i[0] ? (32'hAAAA_AAAA ^ DATA_W'(i)) : (32'h5555_5555 ^ (DATA_W'(i) << 24));
      send_request(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, fill_item);
    end
    send_request(FUNC_PUSH_BACK, '0);
    send_request(FUNC_PUSH_FRONT, '1);

    // long receiver hold-off while requests keep coming
    req_gaps_on = 1'b0;
    hold_off_go = 1'b1;
    sent = 0;
    repeat (PRESSURE_ITEMS) begin
      send_request(pick_op(40), pick_item());
      sent++;
    end

    // random segments, each with its own lean towards adds or takes
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       add_pct = 80;
        1:       add_pct = 20;
        default: add_pct = 50;
      endcase
      if (sent + CALM_TAIL_ITEMS >= RANDOM_ITEMS) begin
        req_gaps_on = 1'b0;
        rsp_gaps_on = 1'b0;
      end else begin
        req_gaps_on = ($urandom_range(0, 3) != 0);
        rsp_gaps_on = ($urandom_range(0, 3) != 0);
      end
      while (seg_len != 0 && sent < RANDOM_ITEMS) begin
        send_request(pick_op(add_pct), pick_item());
        sent++;
        seg_len--;
      end
    end
    req_if.valid <= 1'b0;

    // drain
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests at both ends, %0d responses checked, deepest fill %0d",
             shadow.noted, shadow.checked, shadow.deepest);
    $display("refused takes on empty %0d, refused adds on full %0d, mismatches %0d",
             shadow.empty_refusals, shadow.full_refusals, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bdq_pkg.sv
src/bdq_req_if.sv
src/bdq_rsp_if.sv
src/bdq_cell.sv
src/bounded_deque_core.sv
sim/tb_bounded_deque_core.sv
